[design/qecs_pkg.sv]
package qecs_pkg;

    // default channel count and field widths
    localparam int CHANNELS_DEF = 3;
    localparam int CH_FIELD_W   = 2;
    localparam int POS_W        = 32;
    localparam int TIME_W       = 32;
    localparam int SPEED_W      = 24;
    localparam int INTERVAL_W   = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;

    // register reset values
    localparam logic                  TABLE_MODE_RST   = 1'b1;
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd25;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 1'b1;

    // speed divider: one quotient bit per step
    localparam int DIV_STEPS = 24;
    localparam int DIV_CNT_W = 5;

    // function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_POLL   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_PREP,
        S_DIV,
        S_WB
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic calc_load;
        logic prep;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic poll_upd;
        logic out_free;
    } dp_status_t;

endpackage

[design/qecs_if.sv]
interface qecs_in_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [qecs_pkg::CH_FIELD_W-1:0] channel;
    logic                            sig_a;
    logic                            sig_b;
    logic [qecs_pkg::TIME_W-1:0]     time_ms;

    modport source (output valid, func, channel, sig_a, sig_b, time_ms, input ready);
    modport sink   (input valid, func, channel, sig_a, sig_b, time_ms, output ready);
endinterface

interface qecs_out_if;
    logic                               valid;
    logic                               ready;
    logic [qecs_pkg::CH_FIELD_W-1:0]    out_channel;
    logic signed [qecs_pkg::POS_W-1:0]  position;
    logic signed [qecs_pkg::SPEED_W-1:0] speed;
    logic                               speed_updated;

    modport source (output valid, out_channel, position, speed, speed_updated, input ready);
    modport sink   (input valid, out_channel, position, speed, speed_updated, output ready);
endinterface

[design/qecs_ctrl.sv]
module qecs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  qecs_pkg::dp_status_t   status,
    output qecs_pkg::ctrl_cmd_t    cmd
);

    localparam logic [qecs_pkg::DIV_CNT_W-1:0] DIV_LAST =
        qecs_pkg::DIV_CNT_W'(qecs_pkg::DIV_STEPS - 1);

    qecs_pkg::state_t                 state_reg, state_next;
    logic [qecs_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qecs_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            qecs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = qecs_pkg::S_CALC;
                end
            end
            qecs_pkg::S_CALC:
            begin
                cmd.calc_load = 1'b1;
                state_next    = status.poll_upd ? qecs_pkg::S_PREP : qecs_pkg::S_WB;
            end
            qecs_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = DIV_LAST;
                state_next = qecs_pkg::S_DIV;
            end
            qecs_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = qecs_pkg::S_WB;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            qecs_pkg::S_WB:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = qecs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qecs_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == qecs_pkg::S_CALC))
        else $error("accepted request did not move to calc");
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while output register busy");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qecs_pkg::S_PREP) |=> (cnt_reg == DIV_LAST))
        else $error("divider step count not loaded");
`endif

endmodule

[design/qecs_datapath.sv]
module qecs_datapath #(
    parameter int CHANNELS = qecs_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                wr_en,
    input  logic [qecs_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [qecs_pkg::CFG_DATA_W-1:0]     wr_data,
    // request payload
    input  logic                                in_func,
    input  logic [qecs_pkg::CH_FIELD_W-1:0]     in_channel,
    input  logic                                in_sig_a,
    input  logic                                in_sig_b,
    input  logic [qecs_pkg::TIME_W-1:0]         in_time_ms,
    // result register
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qecs_pkg::CH_FIELD_W-1:0]     out_channel,
    output logic signed [qecs_pkg::POS_W-1:0]   out_position,
    output logic signed [qecs_pkg::SPEED_W-1:0] out_speed,
    output logic                                out_speed_updated,
    // control
    input  qecs_pkg::ctrl_cmd_t                 cmd,
    output qecs_pkg::dp_status_t                status
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = qecs_pkg::POS_W;
    localparam int TW = qecs_pkg::TIME_W;
    localparam int SW = qecs_pkg::SPEED_W;
    localparam int IW = qecs_pkg::INTERVAL_W;
    localparam int HW = PW - qecs_pkg::DIV_STEPS + 8;   // dividend bits above the quotient
    localparam logic [SW-1:0] SPEED_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SPEED_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // count step for an (old, new) phase pair
    function automatic step_t phase_step(input logic mode, input logic [1:0] old_ph,
                                         input logic [1:0] new_ph);
        step_t s;
        s = STEP_NONE;
        if (mode)
        begin
            case ({old_ph, new_ph}) inside
                4'b0001, 4'b0111, 4'b1011, 4'b1101: s = STEP_UP;
                4'b0010, 4'b1110, 4'b1000, 4'b0100: s = STEP_DOWN;
                default:                            s = STEP_NONE;
            endcase
        end
        else
        begin
            case ({old_ph, new_ph}) inside
                4'b0001, 4'b0110, 4'b1011, 4'b1100: s = STEP_UP;
                4'b0011, 4'b0100, 4'b1001, 4'b1110: s = STEP_DOWN;
                default:                            s = STEP_NONE;
            endcase
        end
        return s;
    endfunction

    // configuration
    logic          table_mode_reg;
    logic [IW-1:0] min_int_reg;

    // per-channel state
    logic [1:0]    last_phase_reg [CHANNELS];
    logic [PW-1:0] pulse_reg      [CHANNELS];
    logic [PW-1:0] cnt_last_reg   [CHANNELS];
    logic [TW-1:0] time_last_reg  [CHANNELS];
    logic [SW-1:0] held_reg       [CHANNELS];

    // captured request
    logic                            func_reg;
    logic [qecs_pkg::CH_FIELD_W-1:0] ch_reg;
    logic                            a_reg;
    logic                            b_reg;
    logic [TW-1:0]                   time_reg;

    // speed working registers
    logic [TW-1:0] elapsed_reg;
    logic [PW-1:0] delta_reg;
    logic          upd_reg;
    logic          neg_reg;
    logic          sat_reg;
    logic [TW-1:0] rem_reg;
    logic [qecs_pkg::DIV_STEPS-1:0] dq_reg;

    // result register
    logic                            out_valid_reg;
    logic [qecs_pkg::CH_FIELD_W-1:0] out_ch_reg;
    logic [PW-1:0]                   out_pos_reg;
    logic [SW-1:0]                   out_spd_reg;
    logic                            out_upd_reg;

    logic [CW-1:0] idx;
    logic          in_range;
    logic [TW-1:0] elapsed;
    logic          need_upd;
    logic [PW-1:0] mag;
    logic [TW:0]   trial;
    logic          trial_ge;
    logic [1:0]    phase;
    step_t         step;
    logic [PW-1:0] pulse_new;
    logic [SW-1:0] spd_new;
    logic [SW-1:0] q_neg;

    assign idx      = CW'(ch_reg);
    assign in_range = (32'(ch_reg) < CHANNELS);

    // poll interval check
    assign elapsed  = time_reg - time_last_reg[idx];
    assign need_upd = elapsed > TW'(min_int_reg);

    // magnitude of count change, divider step
    assign mag      = delta_reg[PW-1] ? (~delta_reg + 1'b1) : delta_reg;
    assign trial    = {rem_reg, dq_reg[qecs_pkg::DIV_STEPS-1]};
    assign trial_ge = trial >= {1'b0, elapsed_reg};

    // sample: phase decode and count step
    assign phase = a_reg ? (b_reg ? 2'd2 : 2'd1) : (b_reg ? 2'd3 : 2'd0);
    assign step  = (phase != last_phase_reg[idx])
                 ? phase_step(table_mode_reg, last_phase_reg[idx], phase) : STEP_NONE;

    always_comb
    begin
        pulse_new = pulse_reg[idx];
        if (step == STEP_UP)
            pulse_new = pulse_reg[idx] + 1'b1;
        else if (step == STEP_DOWN)
            pulse_new = pulse_reg[idx] - 1'b1;
    end

    // quotient to saturated signed speed
    assign q_neg = ~dq_reg + 1'b1;
    always_comb
    begin
        if (neg_reg)
            spd_new = (sat_reg || dq_reg > SPEED_MIN) ? SPEED_MIN : q_neg;
        else
            spd_new = (sat_reg || dq_reg[SW-1]) ? SPEED_MAX : dq_reg;
    end

    assign status.poll_upd = in_range && (func_reg == qecs_pkg::FUNC_POLL) && need_upd;
    assign status.out_free = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_mode_reg <= qecs_pkg::TABLE_MODE_RST;
            min_int_reg    <= qecs_pkg::MIN_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == qecs_pkg::CFG_TABLE_MODE)
                table_mode_reg <= wr_data[0];
            else if (wr_index == qecs_pkg::CFG_MIN_INTERVAL)
                min_int_reg <= wr_data[IW-1:0];
        end
    end

    // channel state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_phase_reg[i] <= '0;
                pulse_reg[i]      <= '0;
                cnt_last_reg[i]   <= '0;
                time_last_reg[i]  <= '0;
                held_reg[i]       <= '0;
            end
        end
        else if (cmd.commit && in_range)
        begin
            if (func_reg == qecs_pkg::FUNC_SAMPLE)
            begin
                last_phase_reg[idx] <= phase;
                pulse_reg[idx]      <= pulse_new;
            end
            else if (upd_reg)
            begin
                held_reg[idx]      <= spd_new;
                time_last_reg[idx] <= time_reg;
                cnt_last_reg[idx]  <= pulse_reg[idx];
            end
        end
    end

    // request capture and speed datapath
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            ch_reg   <= in_channel;
            a_reg    <= in_sig_a;
            b_reg    <= in_sig_b;
            time_reg <= in_time_ms;
        end
        if (cmd.calc_load)
        begin
            elapsed_reg <= elapsed;
            delta_reg   <= pulse_reg[idx] - cnt_last_reg[idx];
            upd_reg     <= status.poll_upd;
        end
        if (cmd.prep)
        begin
            // quotient overflows the speed width when the upper dividend
            // bits already reach the divisor
            neg_reg <= delta_reg[PW-1];
            sat_reg <= TW'(mag[PW-1 -: HW]) >= elapsed_reg;
            rem_reg <= TW'(mag[PW-1 -: HW]);
            dq_reg  <= {mag[PW-HW-1:0], 8'h00};
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? TW'(trial - {1'b0, elapsed_reg}) : trial[TW-1:0];
            dq_reg  <= {dq_reg[qecs_pkg::DIV_STEPS-2:0], trial_ge};
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_ch_reg <= ch_reg;
            if (!in_range)
            begin
                out_pos_reg <= '0;
                out_spd_reg <= '0;
                out_upd_reg <= 1'b0;
            end
            else if (func_reg == qecs_pkg::FUNC_SAMPLE)
            begin
                out_pos_reg <= pulse_new;
                out_spd_reg <= held_reg[idx];
                out_upd_reg <= 1'b0;
            end
            else
            begin
                out_pos_reg <= pulse_reg[idx];
                out_spd_reg <= upd_reg ? spd_new : held_reg[idx];
                out_upd_reg <= upd_reg;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_channel       = out_ch_reg;
    assign out_position      = $signed(out_pos_reg);
    assign out_speed         = $signed(out_spd_reg);
    assign out_speed_updated = out_upd_reg;

`ifndef SYNTHESIS
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not presented after commit");
    a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && upd_reg) |-> (in_range && func_reg == qecs_pkg::FUNC_POLL))
        else $error("speed update on sample or unknown channel");
    // remainder is bounded only when the quotient fits the speed width
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sat_reg) |=> (rem_reg < elapsed_reg))
        else $error("divider remainder out of range");
`endif

endmodule

[design/quadrature_encoder_counter_speed_unit.sv]
// Quadrature encoder counter with speed estimate, for up to CHANNELS encoders.
// A sample request (func 0) updates the channel's phase and 32-bit position
// from its A/B levels; a poll request (func 1) carries the ms time and, once
// more than min_interval_ms has passed since the last update, recomputes the
// held speed (counts per ms, signed Q15.8, saturated). Every request returns
// one result with the channel's position and held speed. One request is in
// work at a time; a poll that updates runs the restoring divider, which yields
// one quotient bit per cycle. The result sits in an output register, so the
// next request is taken while a result waits; write-back of a finished request
// stalls only while that register is still full.
// Registers: index 0 table_mode (reset 1), index 1 min_interval_ms (reset 25).
module quadrature_encoder_counter_speed_unit #(
    parameter int CHANNELS = qecs_pkg::CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [qecs_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [qecs_pkg::CFG_DATA_W-1:0]  wr_data,
    qecs_in_if.sink                          sample,
    qecs_out_if.source                       result
);

    qecs_pkg::ctrl_cmd_t  cmd;
    qecs_pkg::dp_status_t status;

    qecs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    qecs_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .in_func           (sample.func),
        .in_channel        (sample.channel),
        .in_sig_a          (sample.sig_a),
        .in_sig_b          (sample.sig_b),
        .in_time_ms        (sample.time_ms),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .out_channel       (result.out_channel),
        .out_position      (result.position),
        .out_speed         (result.speed),
        .out_speed_updated (result.speed_updated),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

[bench/quadrature_encoder_counter_speed_unit_test.sv]
`timescale 1ns / 100ps

module quadrature_encoder_counter_speed_unit_test;

    localparam int CH_COUNT       = qecs_pkg::CHANNELS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 315;
    localparam int RAMP_STEPS     = 16;
    localparam int MAX_REPORTS    = 10;

    // quadrature phases by A/B level: none, A only, both, B only
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_A    = 2'd1;
    localparam logic [1:0] PH_AB   = 2'd2;
    localparam logic [1:0] PH_B    = 2'd3;

    // Q15.8 saturation limits
    localparam logic [qecs_pkg::SPEED_W-1:0] SPEED_TOP    = 24'h7F_FFFF;
    localparam logic [qecs_pkg::SPEED_W-1:0] SPEED_BOTTOM = 24'h80_0000;

    typedef struct packed {
        logic [qecs_pkg::CH_FIELD_W-1:0]   chan;
        logic signed [qecs_pkg::POS_W-1:0] pos;
        logic signed [qecs_pkg::SPEED_W-1:0] spd;
        logic                              upd;
    } reading_t;

    // expectation typed into the directed table, if any
    typedef struct packed {
        logic     known;
        reading_t want;
    } reading_hint_t;

    typedef struct packed {
        logic                            func;
        logic [qecs_pkg::CH_FIELD_W-1:0] chan;
        logic                            a;
        logic                            b;
        logic [qecs_pkg::TIME_W-1:0]     t;
        logic                            known;
        reading_t                        want;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             wr_en;
    logic [qecs_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [qecs_pkg::CFG_DATA_W-1:0]  wr_data;

    qecs_in_if  sample_ch();
    qecs_out_if result_ch();

    quadrature_encoder_counter_speed_unit #(
        .CHANNELS(CH_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .sample(sample_ch),
        .result(result_ch)
    );

    // encoder tracking state, per channel
    logic                            cur_table_mode;
    logic [qecs_pkg::INTERVAL_W-1:0] cur_min_interval;
    logic [1:0]                      ch_phase      [CH_COUNT];
    logic [qecs_pkg::POS_W-1:0]      ch_count      [CH_COUNT];
    logic [qecs_pkg::POS_W-1:0]      ch_count_mark [CH_COUNT];
    logic [qecs_pkg::TIME_W-1:0]     ch_time_mark  [CH_COUNT];
    logic [qecs_pkg::SPEED_W-1:0]    ch_speed      [CH_COUNT];

    reading_t      pending_readings[$];
    reading_hint_t reading_hints[$];
    stim_row_t     directed_rows[$];

    // stimulus side: levels last sent per channel, walk direction, ms clock
    logic [1:0]                  walk_phase [4];
    logic                        walk_fwd   [4];
    logic [qecs_pkg::TIME_W-1:0] now_ms;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [1:0] phase_of(input logic a, input logic b);
        if (a)
            return b ? PH_AB : PH_A;
        return b ? PH_B : PH_NONE;
    endfunction

    function automatic logic [1:0] levels_of(input logic [1:0] ph);
        return {(ph == PH_A) || (ph == PH_AB), (ph == PH_AB) || (ph == PH_B)};
    endfunction

    // count change for one phase change under the selected table
    function automatic int phase_step(input logic mode, input logic [1:0] old_ph,
                                      input logic [1:0] new_ph);
        int step;
        step = 0;
        if (!mode)
        begin
            if (new_ph == old_ph + 2'd1)
                step = 1;
            else if (new_ph == old_ph - 2'd1)
                step = -1;
        end
        else
        begin
            case ({old_ph, new_ph})
                {PH_NONE, PH_A}, {PH_A, PH_B}, {PH_AB, PH_B}, {PH_B, PH_A}:
                    step = 1;
                {PH_NONE, PH_AB}, {PH_B, PH_AB}, {PH_AB, PH_NONE}, {PH_A, PH_NONE}:
                    step = -1;
                default:
                    step = 0;
            endcase
        end
        return step;
    endfunction

    // counts per ms in Q15.8, truncated toward zero, saturated
    function automatic logic [qecs_pkg::SPEED_W-1:0] speed_q8(
        input logic [qecs_pkg::POS_W-1:0]  delta,
        input logic [qecs_pkg::TIME_W-1:0] elapsed);
        logic [qecs_pkg::POS_W:0] mag;
        logic [63:0]              quo;
        mag = delta[qecs_pkg::POS_W-1] ? ({1'b0, ~delta} + 1'b1) : {1'b0, delta};
        quo = ({31'd0, mag} << 8) / {32'd0, elapsed};
        if (delta[qecs_pkg::POS_W-1])
        begin
            if (quo > 64'h80_0000)
                return SPEED_BOTTOM;
            return ~quo[qecs_pkg::SPEED_W-1:0] + 1'b1;
        end
        if (quo > 64'h7F_FFFF)
            return SPEED_TOP;
        return quo[qecs_pkg::SPEED_W-1:0];
    endfunction

    // advance the channel state by one request, return the reading it yields
    function automatic reading_t track_encoder(input logic func, input logic [1:0] chan,
                                               input logic a, input logic b,
                                               input logic [qecs_pkg::TIME_W-1:0] t);
        reading_t                    r;
        logic [1:0]                  ph;
        logic [qecs_pkg::TIME_W-1:0] elapsed;
        r = '0;
        r.chan = chan;
        if (chan < CH_COUNT)
        begin
            if (func == qecs_pkg::FUNC_SAMPLE)
            begin
                ph = phase_of(a, b);
                if (ph != ch_phase[chan])
                begin
                    ch_count[chan] = ch_count[chan] + phase_step(cur_table_mode,
                                                                 ch_phase[chan], ph);
                    ch_phase[chan] = ph;
                end
            end
            else
            begin
                elapsed = t - ch_time_mark[chan];
                if (elapsed > cur_min_interval)
                begin
                    ch_speed[chan]      = speed_q8(ch_count[chan] - ch_count_mark[chan], elapsed);
                    ch_time_mark[chan]  = t;
                    ch_count_mark[chan] = ch_count[chan];
                    r.upd = 1'b1;
                end
            end
            r.pos = ch_count[chan];
            r.spd = ch_speed[chan];
        end
        return r;
    endfunction

    // receiver stalls
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    // prediction on accepted requests, checking of accepted results, watchdog
    always @(posedge clk)
    begin : monitor
        reading_t      got;
        reading_t      want;
        reading_t      predicted;
        reading_hint_t hint;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.chan = result_ch.out_channel;
                got.pos  = result_ch.position;
                got.spd  = result_ch.speed;
                got.upd  = result_ch.speed_updated;
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: ch %0d pos %0d speed %0d upd %0b",
                                 got.chan, $signed(got.pos), $signed(got.spd), got.upd);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.chan !== want.chan || got.pos !== want.pos ||
                        got.spd !== want.spd || got.upd !== want.upd)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result mismatch: expected ch %0d pos %0d speed %0d upd %0b",
                                     want.chan, $signed(want.pos), $signed(want.spd),
                                     want.upd);
                            $display("                 got      ch %0d pos %0d speed %0d upd %0b",
                                     got.chan, $signed(got.pos), $signed(got.spd), got.upd);
                        end
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                predicted = track_encoder(sample_ch.func, sample_ch.channel, sample_ch.sig_a,
                                          sample_ch.sig_b, sample_ch.time_ms);
                hint = reading_hints.pop_front();
                pending_readings.push_back(hint.known ? hint.want : predicted);
            end
            if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [qecs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [qecs_pkg::CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        if (idx == qecs_pkg::CFG_TABLE_MODE)
            cur_table_mode = data[0];
        else
            cur_min_interval = data[qecs_pkg::INTERVAL_W-1:0];
    endtask

    // upper data bits of table_mode are don't-care, so they are randomized
    task automatic set_config(input logic mode,
                              input logic [qecs_pkg::INTERVAL_W-1:0] interval);
        write_reg(qecs_pkg::CFG_TABLE_MODE, {(qecs_pkg::CFG_DATA_W-1)'($urandom), mode});
        write_reg(qecs_pkg::CFG_MIN_INTERVAL, interval);
        wr_en <= 1'b0;
    endtask

    // stop sending, wait for every outstanding result, then let the block settle
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one request through the handshake, with a random idle gap ahead of it
    task automatic send_request(input logic func, input logic [1:0] chan, input logic a,
                                input logic b, input logic [qecs_pkg::TIME_W-1:0] t,
                                input logic known, input reading_t want);
        reading_hint_t hint;
        hint.known = known;
        hint.want  = want;
        if ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        reading_hints.push_back(hint);
        sample_ch.valid   <= 1'b1;
        sample_ch.func    <= func;
        sample_ch.channel <= chan;
        sample_ch.sig_a   <= a;
        sample_ch.sig_b   <= b;
        sample_ch.time_ms <= t;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic add_row(input logic func, input logic [1:0] chan, input logic a,
                           input logic b, input logic [qecs_pkg::TIME_W-1:0] t,
                           input logic known,
                           input logic signed [qecs_pkg::POS_W-1:0] pos,
                           input logic signed [qecs_pkg::SPEED_W-1:0] spd, input logic upd);
        stim_row_t row;
        row.func      = func;
        row.chan      = chan;
        row.a         = a;
        row.b         = b;
        row.t         = t;
        row.known     = known;
        row.want.chan = chan;
        row.want.pos  = pos;
        row.want.spd  = spd;
        row.want.upd  = upd;
        directed_rows.push_back(row);
    endtask

    // mostly one-step walks per channel with random content, plus noise
    task automatic send_random_item();
        logic [1:0] chan;
        logic [1:0] ph;
        logic [1:0] lv;
        reading_t   none;
        none = '0;
        chan = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(CH_COUNT - 1));
        if ($urandom_range(99) < 65)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(99) < 4)
                    walk_fwd[chan] = !walk_fwd[chan];
                ph = walk_phase[chan] + (walk_fwd[chan] ? 2'd1 : 2'd3);
                // occasionally skip a state
                if ($urandom_range(99) < 5)
                    ph = walk_phase[chan] + 2'd2;
            end
            else
                ph = 2'($urandom_range(3));
            walk_phase[chan] = ph;
            lv = levels_of(ph);
            send_request(qecs_pkg::FUNC_SAMPLE, chan, lv[1], lv[0], $urandom, 1'b0, none);
        end
        else
        begin
            if ($urandom_range(99) < 10)
                now_ms = $urandom;
            else
                now_ms = now_ms + $urandom_range(40);
            send_request(qecs_pkg::FUNC_POLL, chan, 1'($urandom_range(1)),
                         1'($urandom_range(1)), now_ms, 1'b0, none);
        end
    endtask

    // drive channel 1 a number of steps one way, then poll 1 ms later
    task automatic ramp_count(input int steps, input logic fwd);
        logic [1:0] lv;
        reading_t   none;
        none = '0;
        repeat (steps)
        begin
            walk_phase[1] = walk_phase[1] + (fwd ? 2'd1 : 2'd3);
            lv = levels_of(walk_phase[1]);
            send_request(qecs_pkg::FUNC_SAMPLE, 2'd1, lv[1], lv[0], $urandom, 1'b0, none);
        end
        now_ms = now_ms + 1;
        send_request(qecs_pkg::FUNC_POLL, 2'd1, 1'b0, 1'b0, now_ms, 1'b0, none);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = qecs_pkg::CFG_TABLE_MODE;
        wr_data           = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.func    = qecs_pkg::FUNC_SAMPLE;
        sample_ch.channel = '0;
        sample_ch.sig_a   = 1'b0;
        sample_ch.sig_b   = 1'b0;
        sample_ch.time_ms = '0;
        result_ch.ready   = 1'b0;

        cur_table_mode   = qecs_pkg::TABLE_MODE_RST;
        cur_min_interval = qecs_pkg::MIN_INTERVAL_RST;
        for (int i = 0; i < CH_COUNT; i++)
        begin
            ch_phase[i]      = PH_NONE;
            ch_count[i]      = '0;
            ch_count_mark[i] = '0;
            ch_time_mark[i]  = '0;
            ch_speed[i]      = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            walk_phase[i] = PH_NONE;
            walk_fwd[i]   = 1'b1;
        end
        now_ms = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset configuration: variant table, 25 ms interval
        add_row(qecs_pkg::FUNC_POLL,   2'd0, 1'b0, 1'b0, 32'd0,         1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd3, 1'b1, 1'b1, $urandom,      1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_POLL,   2'd3, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b0, 1'b0, $urandom,      1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b1, 1'b0, $urandom,      1'b1,  1,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b0, 1'b1, $urandom,      1'b1,  2,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b0, 1'b1, $urandom,      1'b1,  2,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b1, 1'b1, $urandom,      1'b1,  1,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b0, 1'b0, $urandom,      1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b1, 1'b1, $urandom,      1'b1, -1,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd0, 1'b1, 1'b0, $urandom,      1'b1, -1,  0, 1'b0);
        // elapsed equal to the interval holds, one past it updates
        add_row(qecs_pkg::FUNC_POLL,   2'd0, 1'b0, 1'b0, 32'd25,        1'b1, -1,  0, 1'b0);
        add_row(qecs_pkg::FUNC_POLL,   2'd0, 1'b1, 1'b0, 32'd26,        1'b1, -1, -9, 1'b1);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd1, 1'b0, 1'b1, $urandom,      1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd1, 1'b1, 1'b0, $urandom,      1'b1,  1,  0, 1'b0);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd1, 1'b1, 1'b1, $urandom,      1'b0,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_POLL,   2'd1, 1'b0, 1'b1, 32'd100,       1'b0,  0,  0, 1'b0);
        // time wrap around zero
        add_row(qecs_pkg::FUNC_POLL,   2'd2, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1,  0,  0, 1'b1);
        add_row(qecs_pkg::FUNC_POLL,   2'd2, 1'b0, 1'b0, 32'd5,         1'b1,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_POLL,   2'd2, 1'b1, 1'b1, 32'h1A,        1'b1,  0,  0, 1'b1);
        add_row(qecs_pkg::FUNC_SAMPLE, 2'd2, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_POLL,   2'd2, 1'b1, 1'b1, 32'h34,        1'b0,  0,  0, 1'b0);
        add_row(qecs_pkg::FUNC_POLL,   2'd0, 1'b0, 1'b0, 32'd51,        1'b0,  0,  0, 1'b0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].func, directed_rows[i].chan, directed_rows[i].a,
                         directed_rows[i].b, directed_rows[i].t, directed_rows[i].known,
                         directed_rows[i].want);

        // random part, one idling pattern and configuration per phase
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    set_config(1'b0, 16'd0);
                end
                1:
                begin
                    idle_pct  = 73;
                    stall_pct = 0;
                    set_config(1'b1, 16'hFFFF);
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 73;
                    set_config(1'b0, 16'($urandom_range(60, 1)));
                end
                default:
                begin
                    idle_pct  = 12;
                    stall_pct = 12;
                    set_config(1'b1, 16'($urandom_range(65535)));
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS; i++)
            begin
                // sender holds off until the block has emptied
                if (p == 1 && i == RANDOM_ITEMS / 2)
                    drain_results();
                send_random_item();
            end
        end

        // short ramps on channel 1 with 1 ms polls, forward then backward
        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
        set_config(1'b0, 16'd0);
        now_ms = ch_time_mark[1];
        ramp_count(0, 1'b1);
        ramp_count(RAMP_STEPS, 1'b1);
        ramp_count(RAMP_STEPS, 1'b0);

        drain_results();
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
design/qecs_pkg.sv
design/qecs_if.sv
design/qecs_ctrl.sv
design/qecs_datapath.sv
design/quadrature_encoder_counter_speed_unit.sv
bench/quadrature_encoder_counter_speed_unit_test.sv
